>>> rtl/bfa_pkg.sv
// package for the best-fit aligned allocator: types, constants, request codes
package bfa_pkg;

  localparam int FREE_SLOTS  = 64;
  localparam int USED_SLOTS  = 64;
  localparam int ALIGN_BYTES = 64;
  localparam int ADDR_BITS   = 32;

  localparam int FIDX_W = $clog2(FREE_SLOTS);
  localparam int UIDX_W = $clog2(USED_SLOTS);
  localparam int FCNT_W = $clog2(FREE_SLOTS + 1);

  typedef logic [ADDR_BITS-1:0] addr_t;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_PLACE = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_BADPLC  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] req_size;
    logic [31:0] req_addr;
  } req_t;

  typedef struct packed {
    logic [31:0] grant_addr;
    logic [1:0]  status;
    logic [31:0] heap_top;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request and reset scan trackers
    logic scan_clr;  // raised with load; unused by the datapath
    logic scan_step; // advance the scan by one slot of the free or used table
    logic decide;    // compute plan and status from scan results
    logic commit;    // perform table updates
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } sts_t;

  // alignment is a power of two, so the remainder is a mask
  function automatic addr_t align_up(addr_t x);
    addr_t r;
    r = x & addr_t'(ALIGN_BYTES - 1);
    if (r == '0) return x;
    return x + (addr_t'(ALIGN_BYTES) - r);
  endfunction

endpackage

>>> rtl/best_fit_aligned_allocator_top.sv
// Best-fit aligned allocator. One request at a time: after a request is taken
// the free table is read one slot per cycle, then the used table, since the
// used lookup for an allocation needs the best-fit address first. The table
// reads are registered; the scan is followed by a decide and a commit step,
// and then the response is offered. A new request is taken only after the
// response is accepted, so the serial table scan sets the request rate.
// Valid bits clear in reset, so no clearing pass.
module best_fit_aligned_allocator_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bfa_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bfa_pkg::rsp_t out_data
);
  import bfa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  bfa_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req(in_data), .sts(sts), .rsp(out_data)
  );
endmodule

>>> rtl/bfa_ctrl.sv
// sequencer for the allocator: capture, table scan, decide, commit, respond
module bfa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bfa_pkg::sts_t sts,
  output bfa_pkg::cmd_t cmd
);
  import bfa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_COMMIT = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("accepting while a response is pending");
  a_commit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit not followed by response");
  a_decide_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> $past(cmd.scan_step))
    else $error("decide without scan");
endmodule

>>> rtl/bfa_dp.sv
// allocator datapath: free and used tables, slot scan, planning and update
module bfa_dp (
  input  logic          clk,
  input  logic          rst,
  input  bfa_pkg::cmd_t cmd,
  input  bfa_pkg::req_t req,
  output bfa_pkg::sts_t sts,
  output bfa_pkg::rsp_t rsp
);
  import bfa_pkg::*;

  localparam int SCAN_END = FREE_SLOTS + USED_SLOTS;
  localparam int SCAN_W = $clog2(SCAN_END + 1);

  addr_t free_start [FREE_SLOTS];
  addr_t free_length[FREE_SLOTS];
  logic [FREE_SLOTS-1:0] free_valid, free_valid_next;
  addr_t used_start [USED_SLOTS];
  addr_t used_length[USED_SLOTS];
  logic [USED_SLOTS-1:0] used_valid;
  addr_t top_pointer;

  logic [1:0] rtype;
  addr_t rsize, raddr;
  logic [SCAN_W-1:0] sidx;

  // free table is walked first, then the used table, whose key needs the best fit
  logic f_iss, u_iss;
  logic [FIDX_W-1:0] fi;
  logic [UIDX_W-1:0] ui;
  assign f_iss = sidx < SCAN_W'(FREE_SLOTS);
  assign u_iss = !f_iss && (sidx < SCAN_W'(SCAN_END));
  assign fi = FIDX_W'(sidx);
  assign ui = UIDX_W'(sidx - SCAN_W'(FREE_SLOTS));
  assign sts.scan_last = sidx == SCAN_W'(SCAN_END);

  // registered slot reads, evaluated in the cycle after issue
  logic f_rd, u_rd;
  logic [FIDX_W-1:0] rf_i;  addr_t rf_s, rf_l;  logic rf_v;
  logic [UIDX_W-1:0] ru_i;  addr_t ru_s, ru_l;  logic ru_v;

  // scan trackers
  logic best_ok;  logic [FIDX_W-1:0] best;  addr_t best_sz, best_al, best_s, best_l;
  logic p_ok;     logic [FIDX_W-1:0] p_i;   addr_t p_s, p_l; // greatest start <= / < addr
  logic n_ok;     logic [FIDX_W-1:0] n_i;   addr_t n_s, n_l; // least start >= addr
  logic u_ok;     logic [UIDX_W-1:0] u_i;   addr_t u_l;      // used match at the key
  logic ue_ok;    logic [UIDX_W-1:0] ue_i;                    // lowest empty used slot
  logic [FCNT_W-1:0] fcnt;

  addr_t cal, coff, cus, ukey;
  logic fit;
  always_comb begin
    cal  = align_up(rf_s);
    coff = cal - rf_s;
    cus  = rf_l - coff;
    fit  = rf_v && (coff < rf_l) && !(cus < rsize);
    ukey = (rtype != REQ_ALLOC) ? raddr : (best_ok ? best_al : top_pointer);
  end

  // plan registers
  logic [1:0] st;
  addr_t grant;
  logic del_a, del_b;
  logic [FIDX_W-1:0] del_ai, del_bi;
  logic put_a, put_b;
  addr_t pa_s, pa_l, pb_s, pb_l;
  logic uset, uclr;
  logic [UIDX_W-1:0] uidx;
  addr_t ustart, ulen;
  logic top_wr;
  addr_t top_val;

  // lowest invalid free slots for up to two inserts after deletes
  logic [FREE_SLOTS-1:0] fv_after, fv_after2;
  logic [FIDX_W-1:0] e1, e2;
  logic e1_ok, e2_ok;
  always_comb begin
    fv_after = free_valid;
    if (del_a) fv_after[del_ai] = 1'b0;
    if (del_b) fv_after[del_bi] = 1'b0;
    e1 = '0; e1_ok = 1'b0;
    for (int i = FREE_SLOTS - 1; i >= 0; i--)
      if (!fv_after[i]) begin e1 = FIDX_W'(i); e1_ok = 1'b1; end
    fv_after2 = fv_after;
    if (put_a && e1_ok) fv_after2[e1] = 1'b1;
    e2 = '0; e2_ok = 1'b0;
    for (int i = FREE_SLOTS - 1; i >= 0; i--)
      if (!fv_after2[i]) begin e2 = FIDX_W'(i); e2_ok = 1'b1; end
    free_valid_next = fv_after2;
    if (put_b) begin
      if (put_a) begin
        if (e2_ok) free_valid_next[e2] = 1'b1;
      end else if (e1_ok) free_valid_next[e1] = 1'b1;
    end
  end

  // decide-stage arithmetic
  addr_t nt, at_, gap, b_off, b_back, b_end, pl_front, pl_back, fr_end, nl, fs;
  logic mp, mn, u_room;
  logic [UIDX_W-1:0] u_slot;
  always_comb begin
    nt = top_pointer + rsize;
    at_ = align_up(nt);
    gap = at_ - nt;
    b_off = best_al - best_s;
    b_back = best_l - rsize - b_off;
    b_end = best_al + rsize;
    pl_front = raddr - p_s;
    pl_back = p_l - rsize - pl_front;
    fr_end = raddr + u_l;
    mp = p_ok && ((p_s + p_l) == raddr);
    mn = n_ok && (n_s == fr_end);
    fs = mp ? p_s : raddr;
    nl = u_l + (mp ? p_l : '0) + (mn ? n_l : '0);
    u_room = u_ok || ue_ok;
    u_slot = u_ok ? u_i : ue_i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_valid <= '0;
      used_valid <= '0;
      top_pointer <= '0;
      f_rd <= 1'b0;
      u_rd <= 1'b0;
    end else begin
      f_rd <= cmd.scan_step && f_iss;
      u_rd <= cmd.scan_step && u_iss;
      if (cmd.scan_step) begin
        rf_i <= fi; rf_s <= free_start[fi]; rf_l <= free_length[fi]; rf_v <= free_valid[fi];
        ru_i <= ui; ru_s <= used_start[ui]; ru_l <= used_length[ui]; ru_v <= used_valid[ui];
        sidx <= sidx + SCAN_W'(1);
      end
      if (cmd.load) begin
        rtype <= req.req_type;
        rsize <= req.req_size;
        raddr <= req.req_addr;
        sidx <= '0;
        best_ok <= 1'b0; p_ok <= 1'b0; n_ok <= 1'b0;
        u_ok <= 1'b0; ue_ok <= 1'b0;
        fcnt <= '0;
      end
      if (f_rd && rf_v) begin
        fcnt <= fcnt + FCNT_W'(1);
        if (rtype == REQ_PLACE) begin
          if (rf_s <= raddr && (!p_ok || rf_s > p_s)) begin
            p_ok <= 1'b1; p_i <= rf_i; p_s <= rf_s; p_l <= rf_l;
          end
        end else if (rtype == REQ_FREE) begin
          if (rf_s < raddr) begin
            if (!p_ok || rf_s > p_s) begin
              p_ok <= 1'b1; p_i <= rf_i; p_s <= rf_s; p_l <= rf_l;
            end
          end else if (!n_ok || rf_s < n_s) begin
            n_ok <= 1'b1; n_i <= rf_i; n_s <= rf_s; n_l <= rf_l;
          end
        end
      end
      if (f_rd && rtype == REQ_ALLOC && fit &&
          (!best_ok || cus < best_sz || (cus == best_sz && cal < best_al))) begin
        best_ok <= 1'b1; best <= rf_i; best_sz <= cus; best_al <= cal;
        best_s <= rf_s; best_l <= rf_l;
      end
      if (u_rd) begin
        if (ru_v && ru_s == ukey && !u_ok) begin
          u_ok <= 1'b1; u_i <= ru_i; u_l <= ru_l;
        end
        if (!ru_v && !ue_ok) begin
          ue_ok <= 1'b1; ue_i <= ru_i;
        end
      end
      if (cmd.decide) begin
        st <= ST_OK; grant <= '0;
        del_a <= 1'b0; del_b <= 1'b0; put_a <= 1'b0; put_b <= 1'b0;
        uset <= 1'b0; uclr <= 1'b0; top_wr <= 1'b0;
        case (rtype)
          REQ_ALLOC: begin
            if (!best_ok) begin
              if ((32'(fcnt) + 32'(gap != '0) > 32'(FREE_SLOTS)) || !u_room)
                st <= ST_FULL;
              else begin
                put_a <= gap != '0; pa_s <= nt; pa_l <= gap;
                top_wr <= 1'b1; top_val <= at_;
                uset <= 1'b1; uidx <= u_slot;
                ustart <= top_pointer; ulen <= rsize; grant <= top_pointer;
              end
            end else begin
              if ((32'(fcnt) - 32'(1) + 32'(b_off != '0) + 32'(b_back != '0)
                   > 32'(FREE_SLOTS)) || !u_room)
                st <= ST_FULL;
              else begin
                del_a <= 1'b1; del_ai <= best;
                put_a <= b_off != '0; pa_s <= best_s; pa_l <= b_off;
                put_b <= b_back != '0; pb_s <= b_end; pb_l <= b_back;
                uset <= 1'b1; uidx <= u_slot;
                ustart <= best_al; ulen <= rsize; grant <= best_al;
              end
            end
          end
          REQ_PLACE: begin
            if (!p_ok || rsize > p_l || pl_front > p_l - rsize) st <= ST_BADPLC;
            else if ((32'(fcnt) - 32'(1) + 32'(pl_front != '0) + 32'(pl_back != '0)
                      > 32'(FREE_SLOTS)) || !u_room)
              st <= ST_FULL;
            else begin
              del_a <= 1'b1; del_ai <= p_i;
              put_a <= pl_front != '0; pa_s <= p_s; pa_l <= pl_front;
              put_b <= pl_back != '0; pb_s <= raddr + rsize; pb_l <= pl_back;
              uset <= 1'b1; uidx <= u_slot;
              ustart <= raddr; ulen <= rsize; grant <= raddr;
            end
          end
          REQ_FREE: begin
            if (!u_ok) st <= ST_UNKNOWN;
            else if (32'(fcnt) - 32'(mp) - 32'(mn) + 32'(nl != '0) > 32'(FREE_SLOTS))
              st <= ST_FULL;
            else begin
              del_a <= mp; del_ai <= p_i;
              del_b <= mn; del_bi <= n_i;
              put_a <= nl != '0; pa_s <= fs; pa_l <= nl;
              uclr <= 1'b1; uidx <= u_i;
            end
          end
          default: ;
        endcase
      end
      if (cmd.commit && st == ST_OK) begin
        free_valid <= free_valid_next;
        if (put_a && e1_ok) begin
          free_start[e1] <= pa_s; free_length[e1] <= pa_l;
        end
        if (put_b) begin
          if (put_a) begin
            if (e2_ok) begin
              free_start[e2] <= pb_s; free_length[e2] <= pb_l;
            end
          end else if (e1_ok) begin
            free_start[e1] <= pb_s; free_length[e1] <= pb_l;
          end
        end
        if (uset) begin
          used_valid[uidx] <= 1'b1;
          used_start[uidx] <= ustart;
          used_length[uidx] <= ulen;
        end
        if (uclr) used_valid[uidx] <= 1'b0;
        if (top_wr) top_pointer <= top_val;
      end
    end
  end

  assign rsp.grant_addr = grant;
  assign rsp.status = st;
  assign rsp.heap_top = top_pointer;

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> 32'(fcnt) <= 32'(FREE_SLOTS))
    else $error("free count out of range");
  a_top_aligned: assert property (@(posedge clk) disable iff (rst)
    (top_pointer & addr_t'(ALIGN_BYTES - 1)) == '0)
    else $error("heap top not aligned");
  a_err_no_grant: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.commit) && st != ST_OK |-> grant == '0)
    else $error("grant on error");
endmodule
